// ----- src/cshpc_pkg.sv -----
`default_nettype none

package cshpc_pkg;

    // Half-period counter width
    localparam int COUNT_BITS = 16;
    // Width of the limit registers and of the reported count fields
    localparam int FIELD_W    = 16;
    // Common width for count vs. limit compares
    localparam int CMP_W      = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LIMIT = 8'd1;

    localparam logic [FIELD_W-1:0] WHITE_LIMIT_RST = 16'd31;
    localparam logic [FIELD_W-1:0] BLACK_LIMIT_RST = 16'd85;

    typedef enum logic [2:0] {
        COL_NONE  = 3'd0,
        COL_RED   = 3'd1,
        COL_GREEN = 3'd2,
        COL_BLUE  = 3'd3,
        COL_WHITE = 3'd4,
        COL_BLACK = 3'd5
    } t_color;

    typedef struct packed {
        logic               filter_s2;
        logic               filter_s3;
        logic               busy;
        logic               done;
        t_color             color_code;
        logic [FIELD_W-1:0] red_count;
        logic [FIELD_W-1:0] green_count;
        logic [FIELD_W-1:0] blue_count;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // White wins over black; otherwise strictly smallest channel, tie -> none
    function automatic t_color classify(
        input logic [CMP_W-1:0] r,
        input logic [CMP_W-1:0] g,
        input logic [CMP_W-1:0] b,
        input logic [CMP_W-1:0] w,
        input logic [CMP_W-1:0] k
    );
        t_color c;
        if (r < w && g < w && b < w) begin
            c = COL_WHITE;
        end else if (r > k && g > k && b > k) begin
            c = COL_BLACK;
        end else if (r < b && r < g) begin
            c = COL_RED;
        end else if (g < b && g < r) begin
            c = COL_GREEN;
        end else if (b < r && b < g) begin
            c = COL_BLUE;
        end else begin
            c = COL_NONE;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/cshpc_meas.sv -----
`default_nettype none

module cshpc_meas
    import cshpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_start_req,
    input  wire logic               i_sensor_level,
    input  wire logic [FIELD_W-1:0] i_white_limit,
    input  wire logic [FIELD_W-1:0] i_black_limit,
    output t_result                 o_res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RED   = 2'd1,
        PH_GREEN = 2'd2,
        PH_BLUE  = 2'd3
    } t_phase;

    t_phase                r_phase,  n_phase;
    logic                  r_edge,   n_edge;
    logic                  r_entry,  n_entry;
    logic [COUNT_BITS-1:0] r_tick,   n_tick;
    logic [COUNT_BITS-1:0] r_red,    n_red;
    logic [COUNT_BITS-1:0] r_green,  n_green;
    logic [COUNT_BITS-1:0] r_blue,   n_blue;
    logic                  done;

    always_comb begin
        n_phase = r_phase;
        n_edge  = r_edge;
        n_entry = r_entry;
        n_tick  = r_tick;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        done    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_RED;
                    n_edge  = 1'b0;
                    n_entry = i_sensor_level;
                end
            end
            default: begin
                if (!r_edge) begin
                    // waiting for the level to leave its entry value
                    if (i_sensor_level != r_entry) begin
                        n_edge = 1'b1;
                        n_tick = '0;
                    end
                end else begin
                    if (r_tick != CNT_MAX) begin
                        n_tick = r_tick + 1'b1;
                    end
                    if (i_sensor_level == r_entry) begin
                        case (r_phase)
                            PH_RED: begin
                                n_red   = n_tick;
                                n_phase = PH_GREEN;
                            end
                            PH_GREEN: begin
                                n_green = n_tick;
                                n_phase = PH_BLUE;
                            end
                            default: begin
                                n_blue  = n_tick;
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        endcase
                        n_edge  = 1'b0;
                        n_entry = i_sensor_level;
                    end
                end
            end
        endcase
    end

    always_comb begin
        o_res.filter_s2   = (n_phase == PH_GREEN);
        o_res.filter_s3   = (n_phase == PH_GREEN) || (n_phase == PH_BLUE);
        o_res.busy        = (n_phase != PH_IDLE);
        o_res.done        = done;
        o_res.color_code  = done ? classify(CMP_W'(n_red), CMP_W'(n_green), CMP_W'(n_blue),
                                            CMP_W'(i_white_limit), CMP_W'(i_black_limit))
                                 : COL_NONE;
        o_res.red_count   = FIELD_W'(n_red);
        o_res.green_count = FIELD_W'(n_green);
        o_res.blue_count  = FIELD_W'(n_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_edge  <= 1'b0;
            r_entry <= 1'b0;
            r_tick  <= '0;
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_edge  <= n_edge;
            r_entry <= n_entry;
            r_tick  <= n_tick;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

endmodule

`default_nettype wire

// ----- src/cshpc_skid.sv -----
`default_nettype none

module cshpc_skid
    import cshpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_result   i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_data
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    push;
    logic    main_free;

    assign o_ready   = !r_skid_v;
    assign o_valid   = r_main_v;
    assign o_data    = r_main;
    assign push      = i_valid && !r_skid_v;
    assign main_free = !r_main_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (main_free) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            if (r_skid_v) begin
                r_main <= r_skid;
            end else if (push) begin
                r_main <= i_data;
            end
        end else if (push) begin
            r_skid <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry held with empty output register");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_v && !i_ready) |=> (r_main_v && $stable(r_main)))
        else $error("stalled result changed or dropped");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_ready) |=> (!r_skid_v && r_main_v && r_main == $past(r_skid)))
        else $error("skid entry not moved to output register");
`endif

endmodule

`default_nettype wire

// ----- src/color_sensor_half_period_classifier_core.sv -----
`default_nettype none

// Color sensor half-period classifier. Each input transfer is one timer tick
// carrying a start request (tdata bit 0) and the sampled sensor output level
// (tdata bit 1). On start while idle the block walks red, green and blue filter
// selects, times one half period of the sensor output per channel (counts
// saturate at the maximum), and on the tick the blue count is stored raises
// done with a color code: white if all counts are below white_limit, else black
// if all are above black_limit, else the strictly smallest channel, else none.
// Every input transfer yields exactly one output transfer showing the state
// after that tick. Rate: one tick per clock while tready is high; each result
// is registered in the output or skid register. The per-tick update is one
// pass through the phase logic between the state and output registers; a
// two-entry output buffer keeps accepting input in a downstream stall until
// the skid entry fills, then tready drops. Config writes are always accepted
// (o_cfg_ready is tied high) and should be issued only while idle.
module color_sensor_half_period_classifier_core
    import cshpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Input tick stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [7:0]           i_s_axis_tdata,  // [0] start_req, [1] sensor_level,
                                                       // [7:2] zero

    // Result stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [55:0]               o_m_axis_tdata,  // [0] filter_s2, [1] filter_s3,
                                                       // [2] busy_res, [3] done_res,
                                                       // [6:4] color_code,
                                                       // [22:7] red_count,
                                                       // [38:23] green_count,
                                                       // [54:39] blue_count, [55] zero

    // Configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FIELD_W-1:0]   i_cfg_data
);

    logic [FIELD_W-1:0] r_white_limit;
    logic [FIELD_W-1:0] r_black_limit;
    logic               in_xfer;
    t_result            step_res;
    t_result            out_res;

    // Limit registers; writes to unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_limit <= WHITE_LIMIT_RST;
            r_black_limit <= BLACK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WHITE_LIMIT: r_white_limit <= i_cfg_data;
                CFG_BLACK_LIMIT: r_black_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A tick advances the measurement only on an accepted transfer
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    cshpc_meas u_meas (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_xfer),
        .i_start_req    (i_s_axis_tdata[0]),
        .i_sensor_level (i_s_axis_tdata[1]),
        .i_white_limit  (r_white_limit),
        .i_black_limit  (r_black_limit),
        .o_res          (step_res)
    );

    cshpc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (step_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_res)
    );

    assign o_m_axis_tdata = {1'b0,
                             out_res.blue_count,
                             out_res.green_count,
                             out_res.red_count,
                             out_res.color_code,
                             out_res.done,
                             out_res.busy,
                             out_res.filter_s3,
                             out_res.filter_s2};

endmodule

`default_nettype wire
